>>> hw/rtl/metc_pkg.sv
// Shared types, constants and the color palette of the escape-time block.
package metc_pkg;

    localparam int C_COORD_W   = 31;   // width of one coordinate of c
    localparam int C_COUNT_W   = 16;   // width of counts and of the limit
    localparam int C_CLASS_W   = 3;
    localparam int C_CHAN_W    = 8;
    localparam int C_Q10_W     = 13;   // 65535 / 10 fits 13 bits
    localparam int C_Q100_W    = 10;   // 65535 / 100 fits 10 bits
    localparam int C_RECIP10   = 52429;  // ceil(2^19 / 10), exact for 16-bit dividends
    localparam int C_RECIP_SHF = 19;
    localparam logic [C_COUNT_W-1:0] C_MAX_ITER_RST = 16'd1000;

    typedef enum logic [C_CLASS_W-1:0] {
        CLS_BLACK      = 3'd0,
        CLS_ORANGE     = 3'd1,
        CLS_RED        = 3'd2,
        CLS_DARK_BLUE  = 3'd3,
        CLS_YELLOW     = 3'd4,
        CLS_DARK_GREEN = 3'd5,
        CLS_CYAN       = 3'd6
    } t_color_class;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // take a new point, z = c, count = 0
        logic mul;       // register partial products of x*x, y*y, x*y
        logic sum;       // combine partial products
        logic add;       // form |z|^2, x*x - y*y and 2*x*y
        logic upd;       // write z*z + c, advance the count
        logic out_load;  // write the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stop;      // limit reached or a component beyond radius two
        logic esc;       // |z|^2 above four
        logic out_free;  // result register empty or being taken
    } t_sts;

    function automatic logic [3*C_CHAN_W-1:0] color_rgb(input t_color_class cls);
        logic [3*C_CHAN_W-1:0] rgb;
        case (cls)
            CLS_BLACK:      rgb = 24'h000000;
            CLS_ORANGE:     rgb = 24'hFF8000;
            CLS_RED:        rgb = 24'hFF0000;
            CLS_DARK_BLUE:  rgb = 24'h000080;
            CLS_YELLOW:     rgb = 24'hFFFF00;
            CLS_DARK_GREEN: rgb = 24'h004D00;
            CLS_CYAN:       rgb = 24'h00FFFF;
            default:        rgb = 24'h000000;
        endcase
        return rgb;
    endfunction

endpackage

>>> hw/rtl/metc_ctrl.sv
// Sequencer of the escape-time iteration: load, multiply, sum, add, update, emit.
module metc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  metc_pkg::t_sts i_sts,
    output metc_pkg::t_cmd o_cmd
);
    import metc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_ADD,
        S_UPD,
        S_COLOR
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                if (i_sts.stop) begin
                    n_state = S_COLOR;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                if (i_sts.esc) begin
                    n_state = S_COLOR;
                end else begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_MUL;
                end
            end
            S_COLOR: begin
                // hold until the result register can take the item
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> hw/rtl/metc_dpath.sv
// Datapath: point registers, split multipliers, escape test, color bands, result register.
module metc_dpath #(
    parameter int FRAC_BITS = 28
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  metc_pkg::t_cmd                        i_cmd,
    output metc_pkg::t_sts                        o_sts,
    input  logic                                  i_cfg_we,
    input  logic [metc_pkg::C_COUNT_W-1:0]        i_cfg_data,
    input  logic signed [metc_pkg::C_COORD_W-1:0] i_c_real,
    input  logic signed [metc_pkg::C_COORD_W-1:0] i_c_imag,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic [metc_pkg::C_COUNT_W-1:0]        o_iter_count,
    output logic [metc_pkg::C_CLASS_W-1:0]        o_color_class,
    output logic [metc_pkg::C_CHAN_W-1:0]         o_red,
    output logic [metc_pkg::C_CHAN_W-1:0]         o_green,
    output logic [metc_pkg::C_CHAN_W-1:0]         o_blue
);
    import metc_pkg::*;

    localparam int Z_A    = (FRAC_BITS + 2 > C_COORD_W - 1) ? FRAC_BITS + 2 : C_COORD_W - 1;
    localparam int Z_W    = Z_A + 2;              // z plus c never overflows this
    localparam int MAG_W  = FRAC_BITS + 2;        // |x| <= 2 when multiplied
    localparam int HALF_W = (MAG_W + 1) / 2;
    localparam int HIGH_W = MAG_W - HALF_W;
    localparam int P_W    = 2 * MAG_W;
    localparam int S_W    = P_W + 1;
    localparam int E_W    = (S_W > Z_W) ? S_W : Z_W;
    localparam int NPROD  = 3;

    localparam logic [Z_W-1:0] TWO = Z_W'(1) << (FRAC_BITS + 1);
    localparam logic [S_W-1:0] LIM = S_W'(1) << (2 * FRAC_BITS + 2);

    logic [C_COUNT_W-1:0]        r_max_iter;
    logic [C_Q10_W-1:0]          r_q10;
    logic [C_Q100_W-1:0]         r_q100;
    logic signed [C_COORD_W-1:0] r_cr;
    logic signed [C_COORD_W-1:0] r_ci;
    logic signed [Z_W-1:0]       r_x;
    logic signed [Z_W-1:0]       r_y;
    logic [C_COUNT_W-1:0]        r_count;
    logic [2*HALF_W-1:0]         r_pp_ll [NPROD];
    logic [MAG_W-1:0]            r_pp_lh [NPROD];
    logic [MAG_W-1:0]            r_pp_hl [NPROD];
    logic [2*HIGH_W-1:0]         r_pp_hh [NPROD];
    logic [P_W-1:0]              r_prod  [NPROD];
    logic [S_W-1:0]              r_mag2;
    logic signed [S_W-1:0]       r_re;
    logic signed [S_W-1:0]       r_im;
    logic                        r_out_valid;
    logic [C_COUNT_W-1:0]        r_iter_count;
    t_color_class                r_class;
    logic [3*C_CHAN_W-1:0]       r_rgb;

    logic [Z_W-1:0]        w_ax;
    logic [Z_W-1:0]        w_ay;
    logic [MAG_W-1:0]      w_opa [NPROD];
    logic [MAG_W-1:0]      w_opb [NPROD];
    logic [S_W-1:0]        w_im2;
    logic signed [E_W-1:0] w_re_e;
    logic signed [E_W-1:0] w_im_e;
    logic signed [E_W-1:0] w_re_sh;
    logic signed [E_W-1:0] w_im_sh;
    logic signed [Z_W-1:0] w_x_new;
    logic signed [Z_W-1:0] w_y_new;
    t_color_class          w_class;

    // limit register and its band thresholds; a write reaches r_q10 and then r_q100, both registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= C_MAX_ITER_RST;
        end else if (i_cfg_we) begin
            r_max_iter <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q10  <= C_Q10_W'((32'(r_max_iter) * 32'(C_RECIP10)) >> C_RECIP_SHF);
        r_q100 <= C_Q100_W'((32'(r_q10) * 32'(C_RECIP10)) >> C_RECIP_SHF);
    end

    assign w_ax = r_x[Z_W-1] ? $unsigned(-r_x) : $unsigned(r_x);
    assign w_ay = r_y[Z_W-1] ? $unsigned(-r_y) : $unsigned(r_y);

    assign o_sts.stop = (w_ax > TWO) || (w_ay > TWO) || (r_count >= r_max_iter);
    assign o_sts.esc  = (r_mag2 > LIM);

    assign w_opa[0] = w_ax[MAG_W-1:0];
    assign w_opb[0] = w_ax[MAG_W-1:0];
    assign w_opa[1] = w_ay[MAG_W-1:0];
    assign w_opb[1] = w_ay[MAG_W-1:0];
    assign w_opa[2] = w_ax[MAG_W-1:0];
    assign w_opb[2] = w_ay[MAG_W-1:0];

    // each product is split into four half-width partials
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            for (int i = 0; i < NPROD; i++) begin
                r_pp_ll[i] <= w_opa[i][HALF_W-1:0] * w_opb[i][HALF_W-1:0];
                r_pp_lh[i] <= w_opa[i][HALF_W-1:0] * w_opb[i][MAG_W-1:HALF_W];
                r_pp_hl[i] <= w_opa[i][MAG_W-1:HALF_W] * w_opb[i][HALF_W-1:0];
                r_pp_hh[i] <= w_opa[i][MAG_W-1:HALF_W] * w_opb[i][MAG_W-1:HALF_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            for (int i = 0; i < NPROD; i++) begin
                r_prod[i] <= (P_W'(r_pp_hh[i]) << (2 * HALF_W))
                           + ((P_W'(r_pp_lh[i]) + P_W'(r_pp_hl[i])) << HALF_W)
                           + P_W'(r_pp_ll[i]);
            end
        end
    end

    assign w_im2 = {r_prod[2], 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_mag2 <= S_W'(r_prod[0]) + S_W'(r_prod[1]);
            r_re   <= $signed(S_W'(r_prod[0]) - S_W'(r_prod[1]));
            r_im   <= (r_x[Z_W-1] ^ r_y[Z_W-1]) ? -$signed(w_im2) : $signed(w_im2);
        end
    end

    // arithmetic shift gives the floor of the scaled product
    assign w_re_e  = E_W'(r_re);
    assign w_im_e  = E_W'(r_im);
    assign w_re_sh = w_re_e >>> FRAC_BITS;
    assign w_im_sh = w_im_e >>> FRAC_BITS;
    assign w_x_new = $signed(w_re_sh[Z_W-1:0]) + Z_W'(r_cr);
    assign w_y_new = $signed(w_im_sh[Z_W-1:0]) + Z_W'(r_ci);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cr    <= i_c_real;
            r_ci    <= i_c_imag;
            r_x     <= Z_W'(i_c_real);
            r_y     <= Z_W'(i_c_imag);
            r_count <= '0;
        end else if (i_cmd.upd) begin
            r_x     <= w_x_new;
            r_y     <= w_y_new;
            r_count <= r_count + 1'b1;
        end
    end

    always_comb begin
        if (r_count >= r_max_iter) begin
            w_class = CLS_BLACK;
        end else if (r_count > (r_max_iter >> 3)) begin
            w_class = CLS_ORANGE;
        end else if (r_count > C_COUNT_W'(r_q10)) begin
            w_class = CLS_RED;
        end else if (r_count > C_COUNT_W'(r_q10 >> 1)) begin
            w_class = CLS_DARK_BLUE;
        end else if (r_count > C_COUNT_W'(r_q10 >> 2)) begin
            w_class = CLS_YELLOW;
        end else if (r_count > C_COUNT_W'(r_q100)) begin
            w_class = CLS_DARK_GREEN;
        end else begin
            w_class = CLS_CYAN;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_iter_count <= r_count;
            r_class      <= w_class;
            r_rgb        <= color_rgb(w_class);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_iter_count  = r_iter_count;
    assign o_color_class = r_class;
    assign o_red         = r_rgb[3*C_CHAN_W-1:2*C_CHAN_W];
    assign o_green       = r_rgb[2*C_CHAN_W-1:C_CHAN_W];
    assign o_blue        = r_rgb[C_CHAN_W-1:0];

endmodule

>>> hw/rtl/mandelbrot_escape_time_color_top.sv
// Top level of the escape-time color block: controller, datapath and checks.
//
// Usage
//   Input channel (i_in_valid / o_in_stall): one item is a point c, i_c_real and
//   i_c_imag, signed with FRAC_BITS fraction bits. An item is taken at a rising
//   edge with i_in_valid high and o_in_stall low.
//   Output channel (o_out_valid / i_out_stall): one result item per point: the
//   count, the color class and 8-bit RGB. It is taken when i_out_stall is low.
//   Config channel (i_cfg_valid / o_cfg_ready): writes max_iter, always ready;
//   write it only while no item is in flight.
//   Timing: one point at a time. Each iteration steps through multiply into
//   split partials, sum partials, add and update. The next item can be taken
//   in the cycle after the result enters the output register, while that
//   result may still wait there.
//   Reset: i_rst_n low for at least one edge clears the controller and the
//   output valid, and sets max_iter to 1000.
//   Stall: a stalled result holds in the output register; a finished point
//   waits in the color state until that register frees up.
module mandelbrot_escape_time_color_top #(
    parameter int FRAC_BITS = 28
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [metc_pkg::C_COORD_W-1:0] i_c_real,
    input  logic signed [metc_pkg::C_COORD_W-1:0] i_c_imag,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [metc_pkg::C_COUNT_W-1:0]        o_iter_count,
    output logic [metc_pkg::C_CLASS_W-1:0]        o_color_class,
    output logic [metc_pkg::C_CHAN_W-1:0]         o_red,
    output logic [metc_pkg::C_CHAN_W-1:0]         o_green,
    output logic [metc_pkg::C_CHAN_W-1:0]         o_blue,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [metc_pkg::C_COUNT_W-1:0]        i_cfg_data
);
    import metc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // the limit register takes a write on any cycle
    assign o_cfg_ready = 1'b1;

    metc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    metc_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_c_real      (i_c_real),
        .i_c_imag      (i_c_imag),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_iter_count  (o_iter_count),
        .o_color_class (o_color_class),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue)
    );

    // a taken item keeps the input side busy the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after an accept");

    // never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("result register loaded while full and stalled");

    // the sequencer issues at most one command per cycle
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command at once");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the escape-time color block, with its own escape-count predictor.
module testbench;

    import metc_pkg::*;

    localparam int C_FRAC        = 28;
    localparam int C_HALF_PERIOD = 4;
    localparam int C_ONE         = 1 << C_FRAC;
    localparam int C_TWO_Q       = 2 * C_ONE;           // 2.0 in the input format
    localparam int C_C_MIN       = -(1 << (C_COORD_W - 1));
    localparam int C_C_MAX       = (1 << (C_COORD_W - 1)) - 1;
    localparam longint C_RADIUS  = longint'(1) << (C_FRAC + 1);
    localparam longint C_FOUR_SQ = longint'(1) << (2 * C_FRAC + 2);
    localparam int C_N_DIRECTED  = 24;
    localparam int C_N_PHASES    = 11;
    localparam int C_COST_CAP    = 1500;      // most random points escape before this count
    localparam int C_IDLE_LIMIT  = 1000000;   // covers the slowest point, at the full 16-bit limit, plus stalls
    localparam int C_TAIL        = 32;

    typedef struct packed {
        logic [C_COUNT_W-1:0] cnt;
        t_color_class         cls;
        logic [C_CHAN_W-1:0]  red;
        logic [C_CHAN_W-1:0]  green;
        logic [C_CHAN_W-1:0]  blue;
    } t_pixel_color;

    // One directed point; checked is set where the result is typed in by hand.
    typedef struct packed {
        logic signed [C_COORD_W-1:0] re;
        logic signed [C_COORD_W-1:0] im;
        logic                        checked;
        t_pixel_color                want;
    } t_pixel_row;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_TWO_OF_THREE,
        STALL_LONG
    } t_stall_mode;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic signed [C_COORD_W-1:0] i_c_real = '0;
    logic signed [C_COORD_W-1:0] i_c_imag = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [C_COUNT_W-1:0]        o_iter_count;
    logic [C_CLASS_W-1:0]        o_color_class;
    logic [C_CHAN_W-1:0]         o_red;
    logic [C_CHAN_W-1:0]         o_green;
    logic [C_CHAN_W-1:0]         o_blue;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [C_COUNT_W-1:0]        i_cfg_data = '0;

    t_pixel_color         pending_colors [$];
    t_pixel_row           directed_rows [C_N_DIRECTED];
    logic [C_COUNT_W-1:0] iter_limit = C_MAX_ITER_RST;
    int                   burst_left = 0;
    int                   mismatch_cnt = 0;
    int                   idle_cycles = 0;
    int                   stall_run = 0;
    t_stall_mode          stall_mode = STALL_NONE;

    mandelbrot_escape_time_color_top #(
        .FRAC_BITS (C_FRAC)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_c_real      (i_c_real),
        .i_c_imag      (i_c_imag),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_iter_count  (o_iter_count),
        .o_color_class (o_color_class),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #C_HALF_PERIOD i_clk = ~i_clk;

    // Convert a real coordinate to the signed input format.
    function automatic logic signed [C_COORD_W-1:0] q28(input real v);
        return C_COORD_W'($rtoi(v * C_ONE));
    endfunction

    // Iterate z = z*z + c from z = c and pick the color band of the final count.
    // Squares are only formed once both components lie within radius two, so
    // 64-bit arithmetic holds every value exactly; >>> floors toward minus infinity.
    function automatic t_pixel_color predict_pixel_color(
        input logic signed [C_COORD_W-1:0] c_re,
        input logic signed [C_COORD_W-1:0] c_im,
        input logic [C_COUNT_W-1:0]        limit_in
    );
        longint       cx, cy, x, y, nx;
        int unsigned  n, limit;
        t_pixel_color res;
        cx    = c_re;
        cy    = c_im;
        x     = cx;
        y     = cy;
        n     = 0;
        limit = limit_in;
        while (n < limit && x >= -C_RADIUS && x <= C_RADIUS && y >= -C_RADIUS
               && y <= C_RADIUS && x * x + y * y <= C_FOUR_SQ) begin
            nx = ((x * x - y * y) >>> C_FRAC) + cx;
            y  = ((2 * x * y) >>> C_FRAC) + cy;
            x  = nx;
            n++;
        end
        res.cnt = n[C_COUNT_W-1:0];
        if (n >= limit)              res.cls = CLS_BLACK;
        else if (n > limit / 8)      res.cls = CLS_ORANGE;
        else if (n > limit / 10)     res.cls = CLS_RED;
        else if (n > limit / 20)     res.cls = CLS_DARK_BLUE;
        else if (n > limit / 40)     res.cls = CLS_YELLOW;
        else if (n > limit / 100)    res.cls = CLS_DARK_GREEN;
        else                         res.cls = CLS_CYAN;
        case (res.cls)
            CLS_ORANGE:     {res.red, res.green, res.blue} = {8'd255, 8'd128, 8'd0};
            CLS_RED:        {res.red, res.green, res.blue} = {8'd255, 8'd0, 8'd0};
            CLS_DARK_BLUE:  {res.red, res.green, res.blue} = {8'd0, 8'd0, 8'd128};
            CLS_YELLOW:     {res.red, res.green, res.blue} = {8'd255, 8'd255, 8'd0};
            CLS_DARK_GREEN: {res.red, res.green, res.blue} = {8'd0, 8'd77, 8'd0};
            CLS_CYAN:       {res.red, res.green, res.blue} = {8'd0, 8'd255, 8'd255};
            default:        {res.red, res.green, res.blue} = {8'd0, 8'd0, 8'd0};
        endcase
        return res;
    endfunction

    function automatic void check_field(
        input string                field,
        input logic [C_COUNT_W-1:0] want,
        input logic [C_COUNT_W-1:0] got
    );
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_cnt++;
        end
    endfunction

    // Pick a point: mostly around the set so counts spread over all bands,
    // some fully random words, some just past radius two, some edge values.
    task automatic random_point(
        output logic signed [C_COORD_W-1:0] re,
        output logic signed [C_COORD_W-1:0] im
    );
        int edge_vals [6];
        int mag;
        edge_vals = '{C_C_MIN, C_C_MAX, 0, -1, C_TWO_Q, -C_TWO_Q};
        case ($urandom_range(0, 9))
            0, 1: begin
                re = C_COORD_W'($urandom());
                im = C_COORD_W'($urandom());
            end
            8: begin
                mag = C_TWO_Q + int'($urandom_range(0, 1 << 20));
                re  = C_COORD_W'($urandom_range(0, 1) ? mag : -mag);
                im  = C_COORD_W'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
                if ($urandom_range(0, 1))
                    {re, im} = {im, re};
            end
            9: begin
                re = C_COORD_W'(edge_vals[$urandom_range(0, 5)]);
                im = C_COORD_W'(edge_vals[$urandom_range(0, 5)]);
            end
            default: begin
                re = C_COORD_W'(int'($urandom_range(0, 3 * C_ONE)) - (C_ONE / 10) * 22);
                im = C_COORD_W'(int'($urandom_range(0, (C_ONE / 10) * 26))
                                - (C_ONE / 10) * 13);
            end
        endcase
    endtask

    // Offer one point and hold it until taken. The sender works in bursts:
    // a gap with valid low opens each burst, and valid drops at its end.
    task automatic send_point(
        input logic signed [C_COORD_W-1:0] re,
        input logic signed [C_COORD_W-1:0] im,
        input t_pixel_color                want
    );
        if (burst_left == 0) begin
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8))
                @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 16);
        end
        i_in_valid <= 1'b1;
        i_c_real   <= re;
        i_c_imag   <= im;
        do @(posedge i_clk); while (o_in_stall);
        pending_colors.push_back(want);
        burst_left--;
        if (burst_left == 0)
            i_in_valid <= 1'b0;
    endtask

    // Drop valid and wait until every result in flight has been taken.
    task automatic wait_drained();
        if (burst_left != 0) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
        end
        while (pending_colors.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_iter_limit(input logic [C_COUNT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        iter_limit = value;
    endtask

    initial begin : stimulus
        t_pixel_color                want;
        logic signed [C_COORD_W-1:0] re, im;
        logic [C_COUNT_W-1:0]        limit_val;
        int                          n_items, tries, pick;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed points at the reset limit of 1000: field extremes, points on
        // and just past radius two, fixed points and cycles inside the set, and
        // a few points near the boundary that land in the middle bands.
        directed_rows = '{
            '{q28(0.0), q28(0.0), 1'b1, '{16'd1000, CLS_BLACK, 8'd0, 8'd0, 8'd0}},
            '{C_C_MIN, C_C_MIN, 1'b1, '{16'd0, CLS_CYAN, 8'd0, 8'd255, 8'd255}},
            '{C_C_MAX, C_C_MAX, 1'b1, '{16'd0, CLS_CYAN, 8'd0, 8'd255, 8'd255}},
            '{C_C_MIN, C_C_MAX, 1'b1, '{16'd0, CLS_CYAN, 8'd0, 8'd255, 8'd255}},
            '{C_C_MAX, C_C_MIN, 1'b1, '{16'd0, CLS_CYAN, 8'd0, 8'd255, 8'd255}},
            '{q28(-2.0), q28(0.0), 1'b1, '{16'd1000, CLS_BLACK, 8'd0, 8'd0, 8'd0}},
            '{q28(2.0), q28(0.0), 1'b1, '{16'd1, CLS_CYAN, 8'd0, 8'd255, 8'd255}},
            '{q28(0.0), q28(2.0), 1'b1, '{16'd1, CLS_CYAN, 8'd0, 8'd255, 8'd255}},
            '{q28(0.0), q28(-2.0), 1'b1, '{16'd1, CLS_CYAN, 8'd0, 8'd255, 8'd255}},
            '{C_TWO_Q + 1, q28(0.0), 1'b1, '{16'd0, CLS_CYAN, 8'd0, 8'd255, 8'd255}},
            '{q28(-1.0), q28(0.0), 1'b1, '{16'd1000, CLS_BLACK, 8'd0, 8'd0, 8'd0}},
            '{-1, -1, 1'b1, '{16'd1000, CLS_BLACK, 8'd0, 8'd0, 8'd0}},
            '{q28(-1.5), q28(1.5), 1'b1, '{16'd0, CLS_CYAN, 8'd0, 8'd255, 8'd255}},
            '{q28(0.25), q28(0.0), 1'b0, '0},
            '{q28(0.26), q28(0.0), 1'b0, '0},
            '{q28(-0.75), q28(0.1), 1'b0, '0},
            '{q28(-1.25), q28(0.2), 1'b0, '0},
            '{q28(0.3), q28(0.5), 1'b0, '0},
            '{q28(-0.1), q28(0.9), 1'b0, '0},
            '{q28(-1.77), q28(0.0), 1'b0, '0},
            '{q28(0.36), q28(0.1), 1'b0, '0},
            '{q28(0.2855), q28(0.01), 1'b0, '0},
            '{q28(-0.7454), q28(0.113), 1'b0, '0},
            '{q28(-0.5), q28(-0.6), 1'b0, '0}
        };
        foreach (directed_rows[k]) begin
            want = directed_rows[k].checked ? directed_rows[k].want
                 : predict_pixel_color(directed_rows[k].re, directed_rows[k].im, iter_limit);
            send_point(directed_rows[k].re, directed_rows[k].im, want);
        end

        // Random phases, each under its own limit. Change the limit only once
        // the block has drained; this also holds the sender until all results are in.
        for (int ph = 0; ph < C_N_PHASES; ph++) begin
            wait_drained();
            pick = $urandom_range(0, 99);
            case (ph)
                0:       limit_val = 16'd1;
                1:       limit_val = 16'hFFFF;
                2:       limit_val = 16'd0;          // a limit of zero makes every point black
                default: limit_val = (pick < 50) ? 16'($urandom_range(2, 120))
                                   : (pick < 85) ? 16'($urandom_range(121, 600))
                                   : 16'($urandom_range(601, 2000));
            endcase
            write_iter_limit(limit_val);
            n_items = (limit_val == 0) ? 20 : 55;
            for (int k = 0; k < n_items; k++) begin
                if (ph == 1 && k == 0) begin
                    // one point that runs the full 16-bit limit
                    re = '0;
                    im = '0;
                end else begin
                    // redraw points that would run for too long under a high limit
                    tries = 0;
                    do begin
                        random_point(re, im);
                        want = predict_pixel_color(re, im, iter_limit);
                        tries++;
                    end while (want.cnt > C_COST_CAP && tries < 20);
                    if (want.cnt > C_COST_CAP) begin
                        re = C_C_MAX;
                        im = C_C_MIN;
                    end
                end
                want = predict_pixel_color(re, im, iter_limit);
                send_point(re, im, want);
            end
        end

        wait_drained();
        repeat (C_TAIL) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Receiver stall pattern: switch between no stall, coin flips, a stall whenever the run
    // count is not a multiple of three, and long stall runs, each for a random stretch.
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_run  <= $urandom_range(16, 200);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            STALL_COIN:         i_out_stall <= 1'($urandom_range(0, 1));
            STALL_TWO_OF_THREE: i_out_stall <= (stall_run % 3 != 0);
            STALL_LONG:         i_out_stall <= (stall_run[4:0] < 5'd20);
            default:            i_out_stall <= 1'b0;
        endcase
    end

    // Compare each taken result with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_pixel_color want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_colors.size() == 0) begin
                $error("result item with none expected: iter_count %0d", o_iter_count);
                mismatch_cnt++;
            end else begin
                want = pending_colors.pop_front();
                check_field("iter_count", want.cnt, o_iter_count);
                check_field("color_class", 16'(want.cls), 16'(o_color_class));
                check_field("red", 16'(want.red), 16'(o_red));
                check_field("green", 16'(want.green), 16'(o_green));
                check_field("blue", 16'(want.blue), 16'(o_blue));
            end
        end
    end

    // Watchdog: end the run when no channel moves an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == C_IDLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

endmodule

>>> filelist.f
hw/rtl/metc_pkg.sv
hw/rtl/metc_ctrl.sv
hw/rtl/metc_dpath.sv
hw/rtl/mandelbrot_escape_time_color_top.sv
tb/testbench.sv
